// ===== hw/rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared types and constants.
// Holds the payload structs, the case codes and the arithmetic widths.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // Root argument width: A is at most 16384 + 3 * 32768 = 114688, 17 bits.
  localparam int unsigned AW = 17;
  // Radicand A * 16384 is 31 bits; the root is 16 bits.
  localparam int unsigned SW = 32;
  localparam int unsigned RW = 16;
  // Dividend magnitude |n| * 8192 with |n| <= 65536 fits in 30 bits.
  localparam int unsigned NW = 18;
  localparam int unsigned DW = 31;
  // Quotient bits kept; anything larger saturates.
  localparam int unsigned QW = 16;

  typedef enum logic [1:0] {
    CaseTrace = 2'd0,
    CaseX     = 2'd1,
    CaseY     = 2'd2,
    CaseZ     = 2'd3
  } case_e;

  typedef struct packed {
    logic signed [15:0] r0c0;
    logic signed [15:0] r0c1;
    logic signed [15:0] r0c2;
    logic signed [15:0] r1c0;
    logic signed [15:0] r1c1;
    logic signed [15:0] r1c2;
    logic signed [15:0] r2c0;
    logic signed [15:0] r2c1;
    logic signed [15:0] r2c2;
  } mat_t;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic [1:0]         case_used;
    logic               bad_input;
  } quat_t;

  // Values that ride along the pipeline beside the arithmetic.
  typedef struct packed {
    case_e               sel;
    logic                bad;
    logic signed [NW-1:0] n0;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
  } side_t;

  function automatic logic signed [15:0] sat16(input logic signed [NW:0] v);
    logic signed [15:0] res;
    if (v > 32767) begin
      res = 16'sh7fff;
    end else if (v < -32768) begin
      res = -16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/rmq_setup.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: case selection.
// Registers the root argument, the case and the three numerators.
// ----------------------------------------------------------------------------
module rmq_setup (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  rmq_pkg::mat_t mat_i,
  output logic          vld_o,
  output logic [rmq_pkg::AW-1:0] arg_o,
  output rmq_pkg::side_t side_o
);
  import rmq_pkg::*;

  logic signed [NW:0] m00, m11, m22, t, a;
  logic signed [NW-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  side_t side_d, side_q;
  logic [AW-1:0] arg_d, arg_q;
  logic vld_q;

  // Diagonal trace and the off-diagonal sums and differences.
  always_comb begin
    m00 = {{(NW-15){mat_i.r0c0[15]}}, mat_i.r0c0};
    m11 = {{(NW-15){mat_i.r1c1[15]}}, mat_i.r1c1};
    m22 = {{(NW-15){mat_i.r2c2[15]}}, mat_i.r2c2};
    t = m00 + m11 + m22;
    d21_12 = NW'(mat_i.r2c1) - NW'(mat_i.r1c2);
    d02_20 = NW'(mat_i.r0c2) - NW'(mat_i.r2c0);
    d10_01 = NW'(mat_i.r1c0) - NW'(mat_i.r0c1);
    s01_10 = NW'(mat_i.r0c1) + NW'(mat_i.r1c0);
    s02_20 = NW'(mat_i.r0c2) + NW'(mat_i.r2c0);
    s12_21 = NW'(mat_i.r1c2) + NW'(mat_i.r2c1);
    side_d = '0;
    if (t > 0) begin
      side_d.sel = CaseTrace;
      a = t + 19'sd16384;
      side_d.n0 = d21_12;
      side_d.n1 = d02_20;
      side_d.n2 = d10_01;
    end else if (m00 > m11 && m00 > m22) begin
      side_d.sel = CaseX;
      a = 19'sd16384 + m00 - m11 - m22;
      side_d.n0 = d21_12;
      side_d.n1 = s01_10;
      side_d.n2 = s02_20;
    end else if (m11 > m22) begin
      side_d.sel = CaseY;
      a = 19'sd16384 + m11 - m00 - m22;
      side_d.n0 = d02_20;
      side_d.n1 = s01_10;
      side_d.n2 = s12_21;
    end else begin
      side_d.sel = CaseZ;
      a = 19'sd16384 + m22 - m00 - m11;
      side_d.n0 = d10_01;
      side_d.n1 = s02_20;
      side_d.n2 = s12_21;
    end
    // A non-positive argument is clamped to one LSB.
    if (a <= 0) begin
      side_d.bad = 1'b1;
      arg_d = AW'(1);
    end else begin
      arg_d = a[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      arg_q  <= arg_d;
      side_q <= side_d;
    end
  end

  assign vld_o  = vld_q;
  assign arg_o  = arg_q;
  assign side_o = side_q;
endmodule

// ===== hw/rtl/rmq_sqrt.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: pipelined integer square root.
// Restoring root of A * 16384, two result bits per stage, eight stages.
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [rmq_pkg::AW-1:0] arg_i,
  input  rmq_pkg::side_t side_i,
  output logic          vld_o,
  output logic [rmq_pkg::RW-1:0] root_o,
  output rmq_pkg::side_t side_o
);
  import rmq_pkg::*;

  localparam int unsigned NS = RW / 2;

  logic                vld_q  [NS+1];
  logic [SW-1:0]       rem_q  [NS+1];
  logic [RW-1:0]       res_q  [NS+1];
  logic [SW-1:0]       rad_q  [NS+1];
  side_t               side_q [NS+1];

  always_comb begin
    vld_q[0]  = vld_i;
    rem_q[0]  = '0;
    res_q[0]  = '0;
    rad_q[0]  = {1'b0, arg_i, 14'd0};
    side_q[0] = side_i;
  end

  // Each stage resolves two bits of the root from four radicand bits.
  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [SW-1:0] rem_d, trial;
    logic [RW-1:0] res_d;
    always_comb begin
      for (int b = 0; b < 2; b++) begin
        if (b == 0) begin
          rem_d = {rem_q[s][SW-3:0], rad_q[s][SW-1:SW-2]};
          res_d = res_q[s];
        end else begin
          rem_d = {rem_d[SW-3:0], rad_q[s][SW-3:SW-4]};
        end
        trial = SW'({res_d, 2'b01});
        if (rem_d >= trial) begin
          rem_d = rem_d - trial;
          res_d = {res_d[RW-2:0], 1'b1};
        end else begin
          res_d = {res_d[RW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_d;
        res_q[s+1]  <= res_d;
        rad_q[s+1]  <= {rad_q[s][SW-5:0], 4'd0};
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign vld_o  = vld_q[NS];
  assign root_o = res_q[NS];
  assign side_o = side_q[NS];
endmodule

// ===== hw/rtl/rmq_div.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: pipelined rounding divider.
// Computes |n| * 8192 / r with round half up on the magnitude, one
// quotient bit per stage for the kept bits, then applies sign and clamp.
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic signed [rmq_pkg::NW-1:0] num_i,
  input  logic [rmq_pkg::RW-1:0] den_i,
  output logic signed [15:0] quo_o
);
  import rmq_pkg::*;

  // Quotient may reach about 2^22 for the smallest root. Any quotient beyond
  // KB bits leaves every kept bit set, which still clamps correctly.
  localparam int unsigned KB = QW + 2;

  logic          neg_q [KB+1];
  logic [DW-1:0] rem_q [KB+1];
  logic [KB-1:0] quo_q [KB+1];
  logic [RW-1:0] den_q [KB+1];
  logic signed [15:0] out_q;

  logic [NW-1:0] mag;
  always_comb begin
    mag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    neg_q[0] = num_i[NW-1];
    rem_q[0] = DW'({mag, 13'd0}) + DW'(den_i >> 1);
    quo_q[0] = '0;
    den_q[0] = den_i;
  end

  // Long division, most significant kept quotient bit first.
  for (genvar s = 0; s < KB; s++) begin : g_stage
    localparam int unsigned SH = KB - 1 - s;
    logic [DW+KB:0] dsh;
    logic [DW-1:0] rem_d;
    logic          bit_d;
    always_comb begin
      dsh   = (DW+KB+1)'(den_q[s]) << SH;
      bit_d = (DW+KB+1)'(rem_q[s]) >= dsh;
      rem_d = bit_d ? DW'((DW+KB+1)'(rem_q[s]) - dsh) : rem_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= rem_d;
        quo_q[s+1] <= {quo_q[s][KB-2:0], bit_d};
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  // Signed result; an oversized quotient reads as all ones and clamps.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= sat16(neg_q[KB] ? -(NW+1)'(quo_q[KB]) : (NW+1)'(quo_q[KB]));
    end
  end

  assign quo_o = out_q;
endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion
// Shepperd four-case conversion of a Q2.14 rotation matrix.
// ----------------------------------------------------------------------------
// One matrix is accepted in every cycle while the output is not stalled,
// and its quaternion passes in order through the case selection register,
// eight stages of the square root (two root bits each), eighteen stages of
// the three parallel dividers (one quotient bit each), a sign and clamp
// stage and the output register. A stall on the output freezes the whole
// pipeline, so nothing is lost or repeated; the input stall follows the
// output stall directly. There is no state between matrices.
module rotation_matrix_to_quaternion (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rmq_pkg::mat_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rmq_pkg::quat_t out_data_o
);
  import rmq_pkg::*;

  localparam int unsigned DL = QW + 3;

  logic en;
  logic s_vld, r_vld;
  logic [AW-1:0] s_arg;
  side_t s_side, r_side;
  logic [RW-1:0] root;
  logic signed [15:0] q0, q1, q2;

  // The pipeline advances whenever the output slot is free or moves on.
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  rmq_setup u_setup (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i), .mat_i(in_data_i),
    .vld_o(s_vld), .arg_o(s_arg), .side_o(s_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_vld), .arg_i(s_arg), .side_i(s_side),
    .vld_o(r_vld), .root_o(root), .side_o(r_side)
  );

  rmq_div u_div0 (.clk_i, .en_i(en), .num_i(r_side.n0), .den_i(root), .quo_o(q0));
  rmq_div u_div1 (.clk_i, .en_i(en), .num_i(r_side.n1), .den_i(root), .quo_o(q1));
  rmq_div u_div2 (.clk_i, .en_i(en), .num_i(r_side.n2), .den_i(root), .quo_o(q2));

  // Delay line for the valid bit, case, flag and large component.
  logic          vld_q  [DL+1];
  case_e         sel_q  [DL+1];
  logic          bad_q  [DL+1];
  logic signed [15:0] big_q [DL+1];
  logic [RW:0]   rnd;

  always_comb begin
    rnd      = (RW+1)'(root) + 1'b1;
    vld_q[0] = r_vld;
    sel_q[0] = r_side.sel;
    bad_q[0] = r_side.bad;
    big_q[0] = 16'(rnd >> 1);
  end

  for (genvar s = 0; s < DL; s++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sel_q[s+1] <= sel_q[s];
        bad_q[s+1] <= bad_q[s];
        big_q[s+1] <= big_q[s];
      end
    end
  end

  // Place the large component and the quotients by case.
  quat_t res_d, res_q;
  logic  out_vld_q;
  always_comb begin
    res_d.case_used = sel_q[DL];
    res_d.bad_input = bad_q[DL];
    case (sel_q[DL])
      CaseTrace: begin
        res_d.qw = big_q[DL]; res_d.qx = q0; res_d.qy = q1; res_d.qz = q2;
      end
      CaseX: begin
        res_d.qx = big_q[DL]; res_d.qw = q0; res_d.qy = q1; res_d.qz = q2;
      end
      CaseY: begin
        res_d.qy = big_q[DL]; res_d.qw = q0; res_d.qx = q1; res_d.qz = q2;
      end
      default: begin
        res_d.qz = big_q[DL]; res_d.qw = q0; res_d.qx = q1; res_d.qy = q2;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[DL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = res_q;

  // A stalled result is held.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held result changed");
  // The input is stalled only while the output is stalled.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");
  // A clamped argument only occurs outside the trace case.
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_input |-> out_data_o.case_used != CaseTrace)
    else $error("clamp flagged with positive trace");

endmodule
